>>> hdl/rbes_pkg.sv
// Shared types, constants and helper functions for the BCD RTC epoch converter.
`default_nettype none

package rbes_pkg;

    localparam int COUNTER_WIDTH_DEF = 32;

    localparam int BIN_W  = 8;
    localparam int DAYS_W = 19;
    localparam int TOD_W  = 20;
    localparam int SDAY_W = 17;
    localparam int PROD_W = DAYS_W + SDAY_W + 1;

    localparam logic [7:0]        TPS_RESET   = 8'd100;
    localparam logic [7:0]        YEAR_OFFSET = 8'd30;   // 2000 - 1970
    localparam logic [SDAY_W-1:0] SECS_DAY    = 17'd86400;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic             valid;
        logic             op;
        logic [BIN_W-1:0] sec;
        logic [BIN_W-1:0] min;
        logic [BIN_W-1:0] hour;
        logic [BIN_W-1:0] day;
        logic [BIN_W-1:0] mon;
        logic [BIN_W-1:0] years;  // years since 1970
    } t_s1;

    typedef struct packed {
        logic                     valid;
        logic                     op;
        logic                     bad;
        logic signed [DAYS_W-1:0] days;
        logic [TOD_W-1:0]         tod;
    } t_s2;

    // No digit check: 0xFF gives 165
    function automatic logic [BIN_W-1:0] bcd_to_bin(input logic [7:0] b);
        logic [BIN_W-1:0] hi;
        hi = {4'b0, b[7:4]};
        return {4'b0, b[3:0]} + (hi << 3) + (hi << 1);
    endfunction

    // Days before each month, February counted as 29 days
    function automatic logic [8:0] days_before_month(input logic [3:0] idx);
        logic [8:0] d;
        case (idx)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd60;
            4'd3:    d = 9'd91;
            4'd4:    d = 9'd121;
            4'd5:    d = 9'd152;
            4'd6:    d = 9'd182;
            4'd7:    d = 9'd213;
            4'd8:    d = 9'd244;
            4'd9:    d = 9'd274;
            4'd10:   d = 9'd305;
            4'd11:   d = 9'd335;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

>>> hdl/rtc_bcd_to_epoch_seconds_clock.sv
// An item passes through the decode, date and commit stages, each of which is registered.
// Throughput: one item per cycle; all stages hold together while the result is not taken.
// The counters are updated in the commit stage, so back-to-back ticks and loads never conflict.
// Reset (synchronous, active low): counters and prescaler cleared, ticks_per_second = 100,
// pipeline emptied.
`default_nettype none

module rtc_bcd_to_epoch_seconds_clock #(
    parameter int COUNTER_WIDTH = rbes_pkg::COUNTER_WIDTH_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    input  wire logic         i_operation,
    input  wire logic [7:0]   i_bcd_second,
    input  wire logic [7:0]   i_bcd_minute,
    input  wire logic [7:0]   i_bcd_hour,
    input  wire logic [7:0]   i_bcd_day,
    input  wire logic [7:0]   i_bcd_month,
    input  wire logic [7:0]   i_bcd_year,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [7:0]   i_cfg_data,
    output logic              o_out_valid,
    input  wire logic         i_out_ready,
    output logic [31:0]       o_epoch_seconds,
    output logic [31:0]       o_tick_count,
    output logic              o_bad_date
);
    import rbes_pkg::*;

    logic w_adv;
    t_s1  w_s1;
    t_s2  w_s2;

    // whole pipeline moves when the result register is empty or being drained
    assign w_adv      = !o_out_valid || i_out_ready;
    assign o_in_ready = w_adv;

    rbes_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv),
        .i_valid      (i_in_valid),
        .i_operation  (i_operation),
        .i_bcd_second (i_bcd_second),
        .i_bcd_minute (i_bcd_minute),
        .i_bcd_hour   (i_bcd_hour),
        .i_bcd_day    (i_bcd_day),
        .i_bcd_month  (i_bcd_month),
        .i_bcd_year   (i_bcd_year),
        .o_s1         (w_s1)
    );

    rbes_date u_date (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_s1    (w_s1),
        .o_s2    (w_s2)
    );

    rbes_counter #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_counter (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_adv           (w_adv),
        .i_s2            (w_s2),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_out_valid     (o_out_valid),
        .o_epoch_seconds (o_epoch_seconds),
        .o_tick_count    (o_tick_count),
        .o_bad_date      (o_bad_date)
    );

endmodule

`default_nettype wire

>>> hdl/rbes_decode.sv
// Input stage: BCD to binary decode into the input register.
`default_nettype none

module rbes_decode (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_adv,
    input  wire logic          i_valid,
    input  wire logic          i_operation,
    input  wire logic [7:0]    i_bcd_second,
    input  wire logic [7:0]    i_bcd_minute,
    input  wire logic [7:0]    i_bcd_hour,
    input  wire logic [7:0]    i_bcd_day,
    input  wire logic [7:0]    i_bcd_month,
    input  wire logic [7:0]    i_bcd_year,
    output rbes_pkg::t_s1      o_s1
);
    import rbes_pkg::*;

    logic             r_valid;
    logic             r_op;
    logic [BIN_W-1:0] r_sec;
    logic [BIN_W-1:0] r_min;
    logic [BIN_W-1:0] r_hour;
    logic [BIN_W-1:0] r_day;
    logic [BIN_W-1:0] r_mon;
    logic [BIN_W-1:0] r_years;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_op    <= i_operation;
            r_sec   <= bcd_to_bin(i_bcd_second);
            r_min   <= bcd_to_bin(i_bcd_minute);
            r_hour  <= bcd_to_bin(i_bcd_hour);
            r_day   <= bcd_to_bin(i_bcd_day);
            r_mon   <= bcd_to_bin(i_bcd_month);
            // max 165 + 30 still fits in 8 bits
            r_years <= bcd_to_bin(i_bcd_year) + YEAR_OFFSET;
        end
    end

    always_comb begin
        o_s1.valid = r_valid;
        o_s1.op    = r_op;
        o_s1.sec   = r_sec;
        o_s1.min   = r_min;
        o_s1.hour  = r_hour;
        o_s1.day   = r_day;
        o_s1.mon   = r_mon;
        o_s1.years = r_years;
    end

endmodule

`default_nettype wire

>>> hdl/rbes_date.sv
// Date stage: day count since 1970 and seconds within the day.
`default_nettype none

module rbes_date (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_adv,
    input  wire rbes_pkg::t_s1 i_s1,
    output rbes_pkg::t_s2      o_s2
);
    import rbes_pkg::*;

    logic [16:0]       s_year_days;
    logic [8:0]        s_yp1;
    logic [8:0]        s_dbm;
    logic              s_adj;
    logic              s_bad;
    logic [DAYS_W-1:0] s_days;
    logic [TOD_W-1:0]  s_tod;

    logic                     r_valid;
    logic                     r_op;
    logic                     r_bad;
    logic signed [DAYS_W-1:0] r_days;
    logic [TOD_W-1:0]         r_tod;

    always_comb begin
        s_year_days = 17'(i_s1.years) * 17'd365;
        s_yp1       = {1'b0, i_s1.years} + 9'd1;
        s_dbm       = days_before_month(i_s1.mon[3:0] - 4'd1);
        // drop Feb 29 from March on outside leap years
        s_adj       = (i_s1.mon > 8'd2) && (i_s1.years[1:0] != 2'd2);
        s_bad       = (i_s1.mon == 8'd0) || (i_s1.mon > 8'd12);
        // true value lies in ~11k .. ~72k, so the wrapped sum reads right as signed
        s_days      = DAYS_W'(s_year_days) + DAYS_W'(s_yp1[8:2]) + DAYS_W'(s_dbm)
                    + DAYS_W'(i_s1.day) - DAYS_W'(s_adj) - DAYS_W'(1);
        s_tod       = TOD_W'(i_s1.hour) * TOD_W'(3600) + TOD_W'(i_s1.min) * TOD_W'(60)
                    + TOD_W'(i_s1.sec);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_s1.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_op   <= i_s1.op;
            r_bad  <= s_bad;
            r_days <= signed'(s_days);
            r_tod  <= s_tod;
        end
    end

    always_comb begin
        o_s2.valid = r_valid;
        o_s2.op    = r_op;
        o_s2.bad   = r_bad;
        o_s2.days  = r_days;
        o_s2.tod   = r_tod;
    end

endmodule

`default_nettype wire

>>> hdl/rbes_counter.sv
// Commit stage: seconds/tick counters, prescaler, config register, result register.
`default_nettype none

module rbes_counter #(
    parameter int COUNTER_WIDTH = rbes_pkg::COUNTER_WIDTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_adv,
    input  wire rbes_pkg::t_s2 i_s2,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [7:0]    i_cfg_data,
    output logic               o_out_valid,
    output logic [31:0]        o_epoch_seconds,
    output logic [31:0]        o_tick_count,
    output logic               o_bad_date
);
    import rbes_pkg::*;

    logic signed [PROD_W-1:0] s_prod;
    logic [COUNTER_WIDTH-1:0] s_load;
    logic [7:0]               s_pre_inc;
    logic                     s_commit;

    logic [COUNTER_WIDTH-1:0] r_sec, n_sec;
    logic [COUNTER_WIDTH-1:0] r_tick, n_tick;
    logic [7:0]               r_pre, n_pre;
    logic                     n_bad;
    logic [7:0]               r_tps;
    logic                     r_out_valid;
    logic [31:0]              r_out_sec;
    logic [31:0]              r_out_tick;
    logic                     r_out_bad;

    assign o_cfg_ready = 1'b1;
    assign s_commit    = i_adv && i_s2.valid;

    always_comb begin
        s_prod    = PROD_W'(i_s2.days) * PROD_W'(signed'({1'b0, SECS_DAY}));
        s_load    = COUNTER_WIDTH'(s_prod) + COUNTER_WIDTH'(i_s2.tod);
        s_pre_inc = r_pre + 8'd1;

        n_sec  = r_sec;
        n_tick = r_tick;
        n_pre  = r_pre;
        n_bad  = 1'b0;
        if (i_s2.op == OP_TICK) begin
            n_tick = r_tick + COUNTER_WIDTH'(1);
            // a setting of zero matches on the 8-bit wrap
            if (s_pre_inc == r_tps) begin
                n_sec = r_sec + COUNTER_WIDTH'(1);
                n_pre = 8'd0;
            end else begin
                n_pre = s_pre_inc;
            end
        end else if (i_s2.bad) begin
            n_bad = 1'b1;
        end else begin
            n_sec  = s_load;
            n_tick = '0;
            n_pre  = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec       <= '0;
            r_tick      <= '0;
            r_pre       <= 8'd0;
            r_tps       <= TPS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_tps <= i_cfg_data;
            end
            if (s_commit) begin
                r_sec  <= n_sec;
                r_tick <= n_tick;
                r_pre  <= n_pre;
            end
            if (i_adv) begin
                r_out_valid <= i_s2.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_out_sec  <= n_sec[31:0];
            r_out_tick <= n_tick[31:0];
            r_out_bad  <= n_bad;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_epoch_seconds = r_out_sec;
    assign o_tick_count    = r_out_tick;
    assign o_bad_date      = r_out_bad;

`ifndef SYNTHESIS
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid)
        else $error("result valid set after reset");

    a_bad_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_commit && i_s2.op == OP_LOAD && i_s2.bad |=>
            r_sec == $past(r_sec) && r_tick == $past(r_tick) && r_pre == $past(r_pre))
        else $error("bad date load changed counter state");

    a_tick_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_commit && i_s2.op == OP_TICK |=> r_tick == $past(r_tick) + COUNTER_WIDTH'(1))
        else $error("tick did not advance tick counter");

    a_load_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_commit && i_s2.op == OP_LOAD && !i_s2.bad |=> r_tick == '0 && r_pre == 8'd0)
        else $error("good load did not clear tick counter and prescaler");

    a_out_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_commit |=> r_out_valid && r_out_sec == r_sec[31:0] && r_out_tick == r_tick[31:0])
        else $error("result register disagrees with counters");
`endif

endmodule

`default_nettype wire
